FILE: design/pecd_pkg.sv
package pecd_pkg;

    // Defaults for the top-level parameters.
    localparam int COOLDOWN_TICKS_DEF = 300;
    localparam int WARP_OFFSET_DEF    = 40;
    localparam int VIRTUAL_MIN_DEF    = -10000;
    localparam int VIRTUAL_MAX_DEF    = 10000;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 14;
    localparam int GEOM_W      = 14;
    localparam int RUN_W       = 8;
    localparam int COORD_W     = 16;
    localparam int COOL_W      = 16;
    localparam int NUM_EDGES   = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_MARGIN   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_MARGIN  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_MARGIN    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_MARGIN = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDED_RUN    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE_BITS     = 4'd7;

    localparam logic [GEOM_W-1:0] MARGIN_RESET     = 14'd40;
    localparam logic [RUN_W-1:0]  NEEDED_RUN_RESET = 8'd4;
    localparam logic [1:0]        MODE_RESET       = 2'b11;
    localparam logic [RUN_W-1:0]  RUN_MAX          = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_MOTION   = 2'd0,
        FUNC_TICK     = 2'd1,
        FUNC_SET      = 2'd2,
        FUNC_RECENTRE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_TOP    = 2'd2,
        EDGE_BOTTOM = 2'd3
    } edge_t;

    typedef struct packed {
        logic [GEOM_W-1:0] screen_width;
        logic [GEOM_W-1:0] screen_height;
        logic [GEOM_W-1:0] left_margin;
        logic [GEOM_W-1:0] right_margin;
        logic [GEOM_W-1:0] top_margin;
        logic [GEOM_W-1:0] bottom_margin;
        logic [RUN_W-1:0]  needed_run;
        logic [1:0]        mode_bits;
    } cfg_t;

    typedef struct packed {
        func_t                     func;
        logic signed [COORD_W-1:0] move_x;
        logic signed [COORD_W-1:0] move_y;
        logic signed [COORD_W-1:0] place_x;
        logic signed [COORD_W-1:0] place_y;
    } item_t;

    typedef struct packed {
        logic                      crossed;
        edge_t                     edge_res;
        logic signed [COORD_W-1:0] cursor_x;
        logic signed [COORD_W-1:0] cursor_y;
    } result_t;

endpackage

FILE: design/pecd_cfg_regs.sv
module pecd_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pecd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pecd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pecd_pkg::cfg_t                     cfg
);

    pecd_pkg::cfg_t cfg_reg;
    pecd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                pecd_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data;
                pecd_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data;
                pecd_pkg::REG_LEFT_MARGIN:   cfg_next.left_margin   = cfg_data;
                pecd_pkg::REG_RIGHT_MARGIN:  cfg_next.right_margin  = cfg_data;
                pecd_pkg::REG_TOP_MARGIN:    cfg_next.top_margin    = cfg_data;
                pecd_pkg::REG_BOTTOM_MARGIN: cfg_next.bottom_margin = cfg_data;
                pecd_pkg::REG_NEEDED_RUN:    cfg_next.needed_run    = cfg_data[7:0];
                pecd_pkg::REG_MODE_BITS:     cfg_next.mode_bits     = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= '0;
            cfg_reg.screen_height <= '0;
            cfg_reg.left_margin   <= pecd_pkg::MARGIN_RESET;
            cfg_reg.right_margin  <= pecd_pkg::MARGIN_RESET;
            cfg_reg.top_margin    <= pecd_pkg::MARGIN_RESET;
            cfg_reg.bottom_margin <= pecd_pkg::MARGIN_RESET;
            cfg_reg.needed_run    <= pecd_pkg::NEEDED_RUN_RESET;
            cfg_reg.mode_bits     <= pecd_pkg::MODE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/pecd_in_reg.sv
module pecd_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [63:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    input  logic            take,
    output logic            item_valid,
    output pecd_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    pecd_pkg::item_t item_reg;
    pecd_pkg::item_t item_next;
    logic            load;

    // The register frees up in the same cycle that its word moves on.
    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load) begin
            valid_next        = 1'b1;
            item_next.func    = pecd_pkg::func_t'(s_tuser);
            item_next.move_x  = s_tdata[15:0];
            item_next.move_y  = s_tdata[31:16];
            item_next.place_x = s_tdata[47:32];
            item_next.place_y = s_tdata[63:48];
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

FILE: design/pecd_core.sv
module pecd_core #(
    parameter int COOLDOWN_TICKS = pecd_pkg::COOLDOWN_TICKS_DEF,
    parameter int WARP_OFFSET    = pecd_pkg::WARP_OFFSET_DEF,
    parameter int VIRTUAL_MIN    = pecd_pkg::VIRTUAL_MIN_DEF,
    parameter int VIRTUAL_MAX    = pecd_pkg::VIRTUAL_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  pecd_pkg::item_t   item,
    input  pecd_pkg::cfg_t    cfg,
    output pecd_pkg::result_t res
);

    localparam int SUM_W = pecd_pkg::COORD_W + 2;
    localparam logic signed [SUM_W-1:0] VMIN = SUM_W'(VIRTUAL_MIN);
    localparam logic signed [SUM_W-1:0] VMAX = SUM_W'(VIRTUAL_MAX);
    localparam logic [pecd_pkg::COOL_W-1:0] COOL_LOAD = pecd_pkg::COOL_W'(COOLDOWN_TICKS);
    localparam logic signed [SUM_W-1:0] WARP_OFF = SUM_W'(WARP_OFFSET);

    logic signed [pecd_pkg::COORD_W-1:0] px_reg, px_next;
    logic signed [pecd_pkg::COORD_W-1:0] py_reg, py_next;
    logic                                pvalid_reg, pvalid_next;
    logic [pecd_pkg::RUN_W-1:0]          runs_reg  [pecd_pkg::NUM_EDGES];
    logic [pecd_pkg::RUN_W-1:0]          runs_next [pecd_pkg::NUM_EDGES];
    logic [pecd_pkg::RUN_W-1:0]          runs_upd  [pecd_pkg::NUM_EDGES];
    logic [pecd_pkg::COOL_W-1:0]         cool_reg, cool_next;

    logic                                usable;
    logic                                moving;
    logic                                tb_en;
    logic signed [pecd_pkg::COORD_W-1:0] centre_x, centre_y;
    logic signed [pecd_pkg::COORD_W-1:0] base_x, base_y;
    logic signed [SUM_W-1:0]             sum_x, sum_y;
    logic signed [pecd_pkg::COORD_W-1:0] mov_x, mov_y;
    logic signed [SUM_W-1:0]             mov_xe, mov_ye;
    logic signed [SUM_W-1:0]             rlim, blim;
    logic signed [SUM_W-1:0]             w1, h1, wl, hl;
    logic signed [pecd_pkg::COORD_W-1:0] warp_lo_x, warp_hi_x, warp_lo_y, warp_hi_y;
    logic [pecd_pkg::NUM_EDGES-1:0]      hit;
    logic [pecd_pkg::NUM_EDGES-1:0]      qual;
    logic [1:0]                          sel;
    logic                                fire;

    function automatic logic signed [pecd_pkg::COORD_W-1:0] clamp_v(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] r;
        r = v;
        if (v < VMIN) begin
            r = VMIN;
        end else if (v > VMAX) begin
            r = VMAX;
        end
        return r[pecd_pkg::COORD_W-1:0];
    endfunction

    assign usable   = (cfg.screen_width != '0) && (cfg.screen_height != '0);
    assign moving   = (item.move_x != '0) || (item.move_y != '0);
    assign tb_en    = cfg.mode_bits[0];
    assign centre_x = pecd_pkg::COORD_W'({1'b0, cfg.screen_width[13:1]});
    assign centre_y = pecd_pkg::COORD_W'({1'b0, cfg.screen_height[13:1]});

    // An unset pointer starts from the screen centre before the motion is added.
    assign base_x = pvalid_reg ? px_reg : centre_x;
    assign base_y = pvalid_reg ? py_reg : centre_y;
    assign sum_x  = SUM_W'(base_x) + SUM_W'(item.move_x);
    assign sum_y  = SUM_W'(base_y) + SUM_W'(item.move_y);
    assign mov_x  = clamp_v(sum_x);
    assign mov_y  = clamp_v(sum_y);
    assign mov_xe = SUM_W'(mov_x);
    assign mov_ye = SUM_W'(mov_y);

    assign rlim = SUM_W'({1'b0, cfg.screen_width}) - SUM_W'(1)
                  - SUM_W'({1'b0, cfg.right_margin});
    assign blim = SUM_W'({1'b0, cfg.screen_height}) - SUM_W'(1)
                  - SUM_W'({1'b0, cfg.bottom_margin});

    // The margins are compared as signed values, so a pointer left of or above
    // the screen still counts as being at that edge.
    assign hit[pecd_pkg::EDGE_LEFT]   = item.move_x < 0
                                        && mov_xe <= signed'(SUM_W'({1'b0, cfg.left_margin}));
    assign hit[pecd_pkg::EDGE_RIGHT]  = item.move_x > 0 && mov_xe >= rlim;
    assign hit[pecd_pkg::EDGE_TOP]    = tb_en && item.move_y < 0
                                        && mov_ye <= signed'(SUM_W'({1'b0, cfg.top_margin}));
    assign hit[pecd_pkg::EDGE_BOTTOM] = tb_en && item.move_y > 0 && mov_ye >= blim;

    always_comb begin
        for (int i = 0; i < pecd_pkg::NUM_EDGES; i++) begin
            if (!hit[i]) begin
                runs_upd[i] = '0;
            end else if (runs_reg[i] == pecd_pkg::RUN_MAX) begin
                runs_upd[i] = runs_reg[i];
            end else begin
                runs_upd[i] = runs_reg[i] + 1'b1;
            end
            qual[i] = runs_upd[i] >= cfg.needed_run;
        end
    end

    // Left has the highest priority, bottom the lowest.
    always_comb begin
        sel = 2'd0;
        for (int i = pecd_pkg::NUM_EDGES - 1; i >= 0; i--) begin
            if (qual[i]) begin
                sel = 2'(i);
            end
        end
    end

    assign fire = (|qual) && (cool_reg == '0);

    // Warp targets on the far side of the crossed edge.
    assign w1 = SUM_W'({1'b0, cfg.screen_width}) - SUM_W'(1);
    assign h1 = SUM_W'({1'b0, cfg.screen_height}) - SUM_W'(1);
    assign wl = w1 - WARP_OFF;
    assign hl = h1 - WARP_OFF;
    assign warp_lo_x = (wl > 0) ? wl[pecd_pkg::COORD_W-1:0] : '0;
    assign warp_hi_x = (WARP_OFF < w1) ? WARP_OFF[pecd_pkg::COORD_W-1:0]
                                        : w1[pecd_pkg::COORD_W-1:0];
    assign warp_lo_y = (hl > 0) ? hl[pecd_pkg::COORD_W-1:0] : '0;
    assign warp_hi_y = (WARP_OFF < h1) ? WARP_OFF[pecd_pkg::COORD_W-1:0]
                                        : h1[pecd_pkg::COORD_W-1:0];

    always_comb begin
        px_next      = px_reg;
        py_next      = py_reg;
        pvalid_next  = pvalid_reg;
        runs_next    = runs_reg;
        cool_next    = cool_reg;
        res.crossed  = 1'b0;
        res.edge_res = pecd_pkg::EDGE_LEFT;
        case (item.func)
            pecd_pkg::FUNC_MOTION: begin
                if (usable && moving) begin
                    px_next     = mov_x;
                    py_next     = mov_y;
                    pvalid_next = 1'b1;
                    runs_next   = runs_upd;
                    if (fire) begin
                        cool_next    = COOL_LOAD;
                        runs_next    = '{default: '0};
                        res.crossed  = 1'b1;
                        res.edge_res = pecd_pkg::edge_t'(sel);
                        if (cfg.mode_bits[1]) begin
                            case (pecd_pkg::edge_t'(sel))
                                pecd_pkg::EDGE_LEFT:   px_next = warp_lo_x;
                                pecd_pkg::EDGE_RIGHT:  px_next = warp_hi_x;
                                pecd_pkg::EDGE_TOP:    py_next = warp_lo_y;
                                pecd_pkg::EDGE_BOTTOM: py_next = warp_hi_y;
                                default: ;
                            endcase
                        end
                    end
                end
            end
            pecd_pkg::FUNC_TICK: begin
                if (cool_reg != '0) begin
                    cool_next = cool_reg - 1'b1;
                end
            end
            pecd_pkg::FUNC_SET: begin
                px_next     = clamp_v(SUM_W'(item.place_x));
                py_next     = clamp_v(SUM_W'(item.place_y));
                pvalid_next = 1'b1;
            end
            pecd_pkg::FUNC_RECENTRE: begin
                px_next     = usable ? centre_x : '0;
                py_next     = usable ? centre_y : '0;
                pvalid_next = usable;
            end
            default: ;
        endcase
        res.cursor_x = px_next;
        res.cursor_y = py_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg     <= '0;
            py_reg     <= '0;
            pvalid_reg <= 1'b0;
            runs_reg   <= '{default: '0};
            cool_reg   <= '0;
        end else if (step) begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            pvalid_reg <= pvalid_next;
            runs_reg   <= runs_next;
            cool_reg   <= cool_next;
        end
    end

`ifndef SYNTH
    a_runs_clear_after_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.crossed |=> runs_reg[0] == '0 && runs_reg[1] == '0
                                && runs_reg[2] == '0 && runs_reg[3] == '0)
        else $error("edge run counts not cleared after a crossing");

    a_cooldown_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.crossed |=> cool_reg == COOL_LOAD)
        else $error("cooldown not restarted after a crossing");

    a_tick_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.func == pecd_pkg::FUNC_TICK && cool_reg != '0
        |=> cool_reg == $past(cool_reg) - 1'b1)
        else $error("cooldown did not count down on a tick");
`endif

endmodule

FILE: design/pointer_edge_crossing_detector.sv
// A word accepted into the input register passes through the core to the result register for m_*.
// Throughput: one word per cycle while m_tready is high; the input and result registers
// each free up in the cycle their word moves on, so both sides may stream back to back.
// Reset (aresetn low, synchronous): pointer at (0,0) and unset, run counts and
// cooldown cleared, both stages empty, registers back to their documented defaults.
module pointer_edge_crossing_detector #(
    parameter int COOLDOWN_TICKS = pecd_pkg::COOLDOWN_TICKS_DEF,
    parameter int WARP_OFFSET    = pecd_pkg::WARP_OFFSET_DEF,
    parameter int VIRTUAL_MIN    = pecd_pkg::VIRTUAL_MIN_DEF,
    parameter int VIRTUAL_MAX    = pecd_pkg::VIRTUAL_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration writes; they are taken in every cycle.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pecd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pecd_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Input word stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,  // move_x, move_y, place_x, place_y
    input  logic [1:0]                       s_tuser,  // func

    // Result word stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata,  // edge_res, cursor_x, cursor_y, zeros
    output logic                             m_tuser   // crossed
);

    pecd_pkg::cfg_t    cfg;
    pecd_pkg::item_t   item;
    pecd_pkg::result_t res;
    pecd_pkg::result_t out_reg;
    logic              item_valid;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;

    // The word in the input register moves to the result register whenever
    // that register is empty or is being emptied in the same cycle. The state
    // is updated in that same cycle, so the next word sees it at once.
    assign advance = item_valid && (!out_valid_reg || m_tready);

    pecd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pecd_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pecd_core #(
        .COOLDOWN_TICKS (COOLDOWN_TICKS),
        .WARP_OFFSET    (WARP_OFFSET),
        .VIRTUAL_MIN    (VIRTUAL_MIN),
        .VIRTUAL_MAX    (VIRTUAL_MAX)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item),
        .cfg     (cfg),
        .res     (res)
    );

    // Result register: holds a finished word until the far side takes it.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.crossed;
    assign m_tdata  = {6'b0, out_reg.cursor_y, out_reg.cursor_x, out_reg.edge_res};

`ifndef SYNTH
    a_moves_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !out_valid_reg |=> out_valid_reg)
        else $error("input word did not move into an empty result register");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> item_valid && out_valid_reg && !m_tready)
        else $error("input held off although the pipeline could move");
`endif

endmodule
